// ===== rtl/core/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TICK_US     = 1000;
    localparam int MS_PER_UNIT = 1000;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // ms to ticks: divide when the tick is longer than 1 ms, multiply when shorter
    localparam int TICK_DIV = (TICK_US > MS_PER_UNIT) ? (TICK_US / MS_PER_UNIT) : 1;
    localparam int TICK_MUL = (TICK_US < MS_PER_UNIT) ? (MS_PER_UNIT / TICK_US) : 1;
    // floor(2^32 / TICK_DIV); quotient estimate is at most one low
    localparam logic [31:0] TICK_RECIP =
        (TICK_DIV > 1) ? 32'((64'd1 << 32) / 64'(TICK_DIV)) : 32'd0;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_MODIFIED  = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NULL_KEY  = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic reply;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        t_req_type req;
        logic      scan_last;
        logic      fire_now;
        logic      pend_valid;
        logic      out_free;
    } t_dp_stat;

    function automatic logic [3:0] slot4(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[3:0];
    endfunction

endpackage

// ===== rtl/core/ptt_ctrl.sv =====
`timescale 1ns / 1ps

module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_dp_stat i_stat,
    output logic     o_s_tready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_hold;
    logic   w_reply_req;

    // a second firing slot cannot advance while the previous notice has nowhere to go
    assign w_hold      = i_stat.fire_now && i_stat.pend_valid && !i_stat.out_free;
    assign w_reply_req = (i_stat.req == REQ_CREATE) || (i_stat.req == REQ_DELETE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!w_hold && i_stat.scan_last) begin
                    n_state = (i_stat.req == REQ_TICK) ? S_FLUSH : S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!w_reply_req || i_stat.out_free) n_state = S_IDLE;
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_SCAN: begin
                o_cmd.step = !w_hold;
            end
            S_DECIDE: begin
                o_cmd.reply = w_reply_req && i_stat.out_free;
            end
            S_FLUSH: begin
                o_cmd.flush = i_stat.pend_valid && i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ptt_datapath.sv =====
`timescale 1ns / 1ps

module ptt_datapath
    import ptt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    logic [15:0] r_owner  [TIMER_SLOTS];
    logic [31:0] r_period [TIMER_SLOTS];
    logic [31:0] r_count  [TIMER_SLOTS];

    t_req_type   r_req;
    logic [15:0] r_key;
    logic [15:0] r_ms;
    logic [47:0] r_prod;
    logic [15:0] r_q0;
    logic [IDX_W-1:0] r_idx;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_idx;
    logic [15:0]      r_pend_key;

    logic        r_out_valid;
    logic        r_out_kind;
    t_status     r_out_status;
    logic [3:0]  r_out_slot;
    logic [15:0] r_out_key;
    logic        r_out_last;

    logic [15:0] w_cur_owner;
    logic        w_occ;
    logic [31:0] w_dec;
    logic        w_fire;
    logic        w_out_free;
    logic [31:0] w_ticks;
    logic [31:0] w_rem;

    logic             w_wr_en;
    logic             w_wr_owner;
    logic             w_wr_clear;
    logic [IDX_W-1:0] w_wr_idx;
    t_status          w_rep_status;
    logic [IDX_W-1:0] w_rep_slot;
    logic [15:0]      w_rep_key;

    assign w_cur_owner = r_owner[r_idx];
    assign w_occ       = (w_cur_owner != 16'd0);
    assign w_dec       = r_count[r_idx] - 32'd1;
    assign w_fire      = (r_req == REQ_TICK) && w_occ && (w_dec == 32'd0);
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign o_stat.req        = r_req;
    assign o_stat.scan_last  = (r_idx == IDX_W'(TIMER_SLOTS - 1));
    assign o_stat.fire_now   = w_fire;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = w_out_free;

    always_comb begin
        w_rem = 32'(r_ms) - 32'(r_q0) * 32'(TICK_DIV);
        if (TICK_US == MS_PER_UNIT) begin
            w_ticks = 32'(r_ms);
        end else if (TICK_US > MS_PER_UNIT) begin
            if (TICK_DIV == 1) begin
                w_ticks = 32'(r_ms);
            end else begin
                w_ticks = 32'(r_q0) + ((w_rem >= 32'(TICK_DIV)) ? 32'd1 : 32'd0);
            end
        end else begin
            w_ticks = 32'(r_ms) * 32'(TICK_MUL);
        end
    end

    always_comb begin
        w_wr_en      = 1'b0;
        w_wr_owner   = 1'b0;
        w_wr_clear   = 1'b0;
        w_wr_idx     = r_hit_idx;
        w_rep_status = ST_NULL_KEY;
        w_rep_slot   = '0;
        w_rep_key    = 16'd0;
        case (r_req)
            REQ_CREATE: begin
                if (r_key == 16'd0) begin
                    w_rep_status = ST_NULL_KEY;
                end else if (r_hit) begin
                    w_wr_en      = 1'b1;
                    w_rep_status = ST_MODIFIED;
                    w_rep_slot   = r_hit_idx;
                    w_rep_key    = r_key;
                end else if (r_free) begin
                    w_wr_en      = 1'b1;
                    w_wr_owner   = 1'b1;
                    w_wr_idx     = r_free_idx;
                    w_rep_status = ST_CREATED;
                    w_rep_slot   = r_free_idx;
                    w_rep_key    = r_key;
                end else begin
                    w_rep_status = ST_FULL;
                    w_rep_key    = r_key;
                end
            end
            REQ_DELETE: begin
                if (r_key == 16'd0) begin
                    w_rep_status = ST_NULL_KEY;
                end else if (r_hit) begin
                    w_wr_en      = 1'b1;
                    w_wr_clear   = 1'b1;
                    w_rep_status = ST_DELETED;
                    w_rep_slot   = r_hit_idx;
                    w_rep_key    = r_key;
                end else begin
                    w_rep_status = ST_NOT_FOUND;
                    w_rep_key    = r_key;
                end
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) r_owner[i] <= 16'd0;
        end else if (i_cmd.reply && w_wr_en) begin
            if (w_wr_clear) r_owner[w_wr_idx] <= 16'd0;
            else if (w_wr_owner) r_owner[w_wr_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply && w_wr_en) begin
            r_period[w_wr_idx] <= w_wr_clear ? 32'd0 : w_ticks;
            r_count[w_wr_idx]  <= w_wr_clear ? 32'd0 : w_ticks;
        end else if (i_cmd.step && (r_req == REQ_TICK) && w_occ) begin
            r_count[r_idx] <= w_fire ? r_period[r_idx] : w_dec;
        end
    end

    // quotient estimate settles from the held period during the slot scan
    always_ff @(posedge i_clk) begin
        r_prod <= 48'(r_ms) * 48'(TICK_RECIP);
        r_q0   <= r_prod[47:32];
        if (i_cmd.load) begin
            r_req <= t_req_type'(i_s_tuser);
            r_key <= i_s_tdata[15:0];
            r_ms  <= i_s_tdata[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (!r_hit && (w_cur_owner == r_key)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_free && !w_occ) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
    end

    // one fired notice is held back so the final one of a tick can carry tlast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && w_fire) begin
            r_pend_valid <= 1'b1;
            r_pend_idx   <= r_idx;
            r_pend_key   <= w_cur_owner;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.reply) begin
            r_out_valid  <= 1'b1;
            r_out_kind   <= KIND_REPLY;
            r_out_status <= w_rep_status;
            r_out_slot   <= slot4(w_rep_slot);
            r_out_key    <= w_rep_key;
            r_out_last   <= 1'b1;
        end else if ((i_cmd.step && w_fire && r_pend_valid) || i_cmd.flush) begin
            r_out_valid  <= 1'b1;
            r_out_kind   <= KIND_FIRED;
            r_out_status <= ST_CREATED;  // status field reads zero on expiry notices
            r_out_slot   <= slot4(r_pend_idx);
            r_out_key    <= r_pend_key;
            r_out_last   <= i_cmd.flush;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_key, r_out_slot, r_out_status};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/core/periodic_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Create/delete: the result is registered after the slot scan and the decide state.
// Tick: fired notices leave as the slot scan passes, the final one from the flush state.
// A new beat is taken only after the one-slot-per-cycle scan and the decide or flush state;
// output back-pressure holds the scan.
// Reset (synchronous, active low) frees every slot at once and empties the output register.

module periodic_timer_table_unit
    import ptt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // owner_key[15:0], period_ms[31:16]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[2:0], slot_index[6:3], fired_key[22:7], zero[23]
    output logic        o_m_tuser,   // result_kind
    output logic        o_m_tlast    // last_of_run
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    ptt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/core/ptt_checker.sv =====
`timescale 1ns / 1ps

module ptt_checker
    import ptt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // one request at a time: the input closes straight after a beat is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input still open after an accepted beat");

    // create and delete give exactly one reply, so it always closes the run
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_REPLY) |-> o_m_tlast)
        else $error("reply without tlast");

    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tdata[2:0] == ST_NULL_KEY) || (o_m_tdata[2:0] == ST_FULL)
            || (o_m_tdata[2:0] == ST_NOT_FOUND)) |-> (o_m_tdata[6:3] == 4'd0))
        else $error("failed request reports a nonzero slot");

    a_fired_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_FIRED)
            |-> (o_m_tdata[2:0] == ST_CREATED) && (o_m_tdata[22:7] != 16'd0))
        else $error("expiry notice with nonzero status or null key");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (.*);

// ===== tb/periodic_timer_table_unit_tb.sv =====
`timescale 1ns / 1ps

module periodic_timer_table_unit_tb;
    import ptt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4 * TIMER_SLOTS + 16;

    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [3:0]  slot;
        logic [15:0] key;
        logic        last;
    } t_timer_note;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;    // owner_key[15:0], period_ms[31:16]
    logic [1:0]  i_s_tuser = '0;    // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // status[2:0], slot_index[6:3], fired_key[22:7], zero[23]
    logic        o_m_tuser;         // result_kind
    logic        o_m_tlast;         // last_of_run

    // shadow timer table
    logic [15:0] owner_of  [TIMER_SLOTS];
    logic [31:0] reload_of [TIMER_SLOTS];
    logic [31:0] count_of  [TIMER_SLOTS];

    t_timer_note expected_notes[$];

    int errors = 0;
    int requests_sent = 0;
    int notes_checked = 0;
    int fires_checked = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;
    int rx_hold_req = 0;
    int rx_hold_ack = 0;
    int rx_hold_left = 0;

    periodic_timer_table_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] ms_to_ticks(input logic [15:0] ms);
        if (TICK_US == MS_PER_UNIT)
            return 32'(ms);
        else if (TICK_US > MS_PER_UNIT)
            return 32'(ms) / 32'(TICK_US / MS_PER_UNIT);
        else
            return 32'(ms) * 32'(MS_PER_UNIT / TICK_US);
    endfunction

    function automatic t_timer_note mk_note(input logic kind, input t_status st,
                                            input int slot, input logic [15:0] key,
                                            input logic last);
        t_timer_note n;
        n.kind   = kind;
        n.status = st;
        n.slot   = 4'(slot);
        n.key    = key;
        n.last   = last;
        return n;
    endfunction

    // Applies one accepted request to the shadow table and queues the notes it causes.
    task automatic timer_table_apply(input logic [1:0] req, input logic [15:0] key,
                                     input logic [15:0] ms);
        logic [31:0]            ticks;
        logic [TIMER_SLOTS-1:0] fired;
        t_status                st;
        int                     hit;
        ticks = ms_to_ticks(ms);
        fired = '0;
        hit   = -1;
        case (req)
            REQ_CREATE, REQ_DELETE: begin
                if (key == 16'd0) begin
                    expected_notes.push_back(mk_note(KIND_REPLY, ST_NULL_KEY, 0, 16'd0, 1'b1));
                end else begin
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (hit < 0 && owner_of[i] == key) hit = i;
                    if (req == REQ_CREATE) begin
                        st = ST_MODIFIED;
                        if (hit < 0) begin
                            st = ST_CREATED;
                            for (int i = 0; i < TIMER_SLOTS; i++)
                                if (hit < 0 && owner_of[i] == 16'd0) hit = i;
                        end
                        if (hit >= 0) begin
                            owner_of[hit]  = key;
                            reload_of[hit] = ticks;
                            count_of[hit]  = ticks;
                            expected_notes.push_back(mk_note(KIND_REPLY, st, hit, key, 1'b1));
                        end else begin
                            expected_notes.push_back(mk_note(KIND_REPLY, ST_FULL, 0, key, 1'b1));
                        end
                    end else if (hit >= 0) begin
                        owner_of[hit]  = '0;
                        reload_of[hit] = '0;
                        count_of[hit]  = '0;
                        expected_notes.push_back(mk_note(KIND_REPLY, ST_DELETED, hit, key, 1'b1));
                    end else begin
                        expected_notes.push_back(mk_note(KIND_REPLY, ST_NOT_FOUND, 0, key, 1'b1));
                    end
                end
            end
            REQ_TICK: begin
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (owner_of[i] != 16'd0) begin
                        count_of[i] = count_of[i] - 32'd1;
                        if (count_of[i] == 32'd0) begin
                            count_of[i] = reload_of[i];
                            fired[i] = 1'b1;
                        end
                    end
                end
                // tlast goes on the highest slot that fired
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (fired[i])
                        expected_notes.push_back(mk_note(KIND_FIRED, ST_CREATED, i, owner_of[i],
                                                         (fired >> (i + 1)) == '0));
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] req, input logic [15:0] key,
                             input logic [15:0] ms);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {ms, key};
        do @(posedge i_clk); while (!o_s_tready);
        timer_table_apply(req, key, ms);
        requests_sent++;
    endtask

    // sender pause until every outstanding note has been seen
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_notes.size() != 0);
    endtask

    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'd0;
        else if (r < 8)
            return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(1, 20));
    endfunction

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'd0;
        else if (r < 10)
            return 16'($urandom_range(0, 65535));
        else if (r < 30)
            return 16'($urandom_range(7, 40));
        return 16'($urandom_range(1, 6));
    endfunction

    // receiver: random tready, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_left = rx_hold_len;
            rx_hold_ack  = rx_hold_req;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : note_check
        t_timer_note got;
        t_timer_note want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind   = o_m_tuser;
            got.status = t_status'(o_m_tdata[2:0]);
            got.slot   = o_m_tdata[6:3];
            got.key    = o_m_tdata[22:7];
            got.last   = o_m_tlast;
            if (expected_notes.size() == 0) begin
                $display("%0t: unexpected beat kind=%0d st=%0d slot=%0d key=%h last=%0d",
                         $time, got.kind, got.status, got.slot, got.key, got.last);
                errors++;
            end else begin
                want = expected_notes.pop_front();
                notes_checked++;
                if (want.kind == KIND_FIRED) fires_checked++;
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.slot !== want.slot || got.key !== want.key ||
                    got.last !== want.last) begin
                    $display("%0t: mismatch exp kind=%0d st=%0d slot=%0d key=%h last=%0d",
                             $time, want.kind, want.status, want.slot, want.key, want.last);
                    $display("%0t:          got kind=%0d st=%0d slot=%0d key=%h last=%0d",
                             $time, got.kind, got.status, got.slot, got.key, got.last);
                    errors++;
                end
            end
        end
    end

    // null keys, unknown delete, extreme keys and periods, zero period, modify, ignored type
    task automatic test_directed_requests();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(REQ_CREATE, 16'h0000, 16'd5);
        send_item(REQ_DELETE, 16'h0000, 16'd0);
        send_item(REQ_DELETE, 16'h1234, 16'd0);
        send_item(REQ_CREATE, 16'hFFFF, 16'd1);
        send_item(REQ_CREATE, 16'h0001, 16'hFFFF);
        send_item(REQ_CREATE, 16'h8000, 16'd0);
        send_item(REQ_CREATE, 16'h00A5, 16'd3);
        send_item(REQ_TICK,   16'h0000, 16'd0);
        send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
        send_item(REQ_CREATE, 16'h0001, 16'd2);
        send_item(REQ_TICK,   16'hFFFF, 16'hFFFF);
        send_item(REQ_TICK,   16'h0000, 16'd0);
        send_item(REQ_TICK,   16'h0000, 16'd0);
        send_item(REQ_DELETE, 16'hFFFF, 16'd0);
        send_item(REQ_TICK,   16'h0000, 16'd0);
        send_item(REQ_DELETE, 16'h8000, 16'd0);
        send_item(REQ_DELETE, 16'h0001, 16'd0);
        send_item(REQ_DELETE, 16'h00A5, 16'd0);
        send_item(REQ_DELETE, 16'h00A5, 16'd0);
        send_item(REQ_TICK,   16'h0000, 16'd0);
        wait_drained();
    endtask

    // fill every slot, then a create into the full table and a modify while full
    task automatic test_table_full();
        for (int i = 0; i < TIMER_SLOTS; i++)
            send_item(REQ_CREATE, 16'(16'h0100 + i), 16'd1);
        send_item(REQ_CREATE, 16'h0200, 16'd4);
        send_item(REQ_CREATE, 16'h0105, 16'd1);
        wait_drained();
    endtask

    // every slot fires on each tick; output held off so the block backs up
    task automatic test_output_backpressure();
        rx_hold_len = 400;
        rx_hold_req++;
        repeat (10) send_item(REQ_TICK, 16'h0000, 16'd0);
        wait_drained();
        for (int i = 0; i < TIMER_SLOTS; i++)
            send_item(REQ_DELETE, 16'(16'h0100 + i), 16'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct);
        int sent;
        int r;
        int idx;
        logic [15:0] key;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
            end else if (r < 45) begin
                send_item(REQ_TICK, 16'($urandom), 16'($urandom));
                sent++;
            end else if (r < 75) begin
                send_item(REQ_CREATE, pick_key(), pick_period());
                sent++;
            end else begin
                // about half of the deletes target the picked slot, when it is live, so stale timers get cleared
                idx = $urandom_range(0, TIMER_SLOTS - 1);
                key = (r < 88 && owner_of[idx] != 16'd0) ? owner_of[idx] : pick_key();
                send_item(REQ_DELETE, key, 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int waited;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            owner_of[i]  = '0;
            reload_of[i] = '0;
            count_of[i]  = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_requests();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(102, 23, 46);
        test_random_traffic(102, 46, 23);
        test_random_traffic(102, 0, 0);

        i_s_tvalid <= 1'b0;
        waited = 0;
        while (expected_notes.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_notes.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_notes.size());
            errors++;
        end

        $display("%0d requests sent, %0d result beats checked (%0d expiry notices)",
                 requests_sent, notes_checked, fires_checked);
        $display("covered null keys, full table, modify, zero period, long stall, idle mixes");
        if (errors == 0)
            $display("periodic_timer_table_unit_tb OK");
        else
            $display("periodic_timer_table_unit_tb NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("periodic_timer_table_unit_tb NOT OK");
        $finish;
    end

endmodule
